>>> rtl/bfifo_pkg.sv
// Shared types and codes for the byte FIFO with frame flag.
// No dependencies.
`default_nettype none

package bfifo_pkg;

    localparam int BYTE_W = 8;
    localparam int FILL_W = 7;
    localparam int MSG_W  = 2;
    localparam int FUNC_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

    localparam logic [MSG_W-1:0] MSG_WAITING  = 2'd0;
    localparam logic [MSG_W-1:0] MSG_READING  = 2'd1;
    localparam logic [MSG_W-1:0] MSG_COMPLETE = 2'd2;

    localparam logic REG_START_DELIM = 1'b0;
    localparam logic REG_STOP_DELIM  = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] push_byte;
    } cmd_t;

    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] out_byte;
        logic [FILL_W-1:0] fill;
        logic [MSG_W-1:0]  msg_state;
        logic              last;
    } rsp_t;

endpackage

`default_nettype wire

>>> rtl/byte_fifo_with_frame_flag.sv
// Byte ring FIFO with start/stop delimiter tracking; top level. Depends on bfifo_pkg.
// Push, clear, refused words: result registered at accept; 1 word/cycle if output is free.
// Pop: store read registered in rd_data_reg, then the result word; next word taken once
// the result loads. Flush of N bytes: first byte as for pop, then one byte per cycle from
// single store read port while output is free; next word taken after the last byte loads.
// Reset clears pointers, count, message state and delimiters; store is left unreset.
`default_nettype none

module byte_fifo_with_frame_flag #(
    parameter int DEPTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_stall,
    input  wire bfifo_pkg::cmd_t  cmd,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output bfifo_pkg::rsp_t       rsp,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic [bfifo_pkg::BYTE_W-1:0] store_mem [DEPTH];
    logic [bfifo_pkg::BYTE_W-1:0] rd_data_reg;

    logic                          state_reg, state_next;
    logic [PW-1:0]                 rptr_reg, rptr_next;
    logic [PW-1:0]                 wptr_reg, wptr_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 left_reg, left_next;
    logic                          pend_reg, pend_next;
    logic                          flush_reg, flush_next;
    logic [bfifo_pkg::MSG_W-1:0]   frame_reg, frame_next;
    logic [bfifo_pkg::BYTE_W-1:0]  start_reg, start_next;
    logic [bfifo_pkg::BYTE_W-1:0]  stop_reg, stop_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    bfifo_pkg::rsp_t               rsp_reg, rsp_next;

    logic          out_free;
    logic          cmd_acc;
    logic          load;
    logic          issue;
    logic          mem_we;
    logic          framing;
    logic          cfg_we;
    logic          last_byte;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] cnt_dec;

    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite;
    assign framing   = (start_reg != '0) && (stop_reg != '0);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = (state_reg != ST_IDLE) || !out_free;
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign load      = (state_reg == ST_DRAIN) && pend_reg && out_free;
    assign issue     = (state_reg == ST_DRAIN) && (left_reg != '0) && (!pend_reg || load);
    assign mem_we    = cmd_acc && (cmd.func == bfifo_pkg::FUNC_PUSH) && (count_reg != CNT_FULL);
    assign cnt_inc   = count_reg + CW'(1);
    assign cnt_dec   = count_reg - CW'(1);
    assign last_byte = (left_reg == '0);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == bfifo_pkg::REG_STOP_DELIM)
        begin
            prdata[bfifo_pkg::BYTE_W-1:0] = stop_reg;
        end
        else
        begin
            prdata[bfifo_pkg::BYTE_W-1:0] = start_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rptr_next      = rptr_reg;
        wptr_next      = wptr_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        pend_next      = pend_reg;
        flush_next     = flush_reg;
        frame_next     = frame_reg;
        start_next     = start_reg;
        stop_next      = stop_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (cfg_we)
        begin
            if (paddr[2] == bfifo_pkg::REG_STOP_DELIM)
            begin
                stop_next = pwdata[bfifo_pkg::BYTE_W-1:0];
            end
            else
            begin
                start_next = pwdata[bfifo_pkg::BYTE_W-1:0];
            end
        end

        if (issue)
        begin
            left_next = left_reg - CW'(1);
            pend_next = 1'b1;
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + PW'(1);
        end
        else if (load)
        begin
            pend_next = 1'b0;
        end

        if (load)
        begin
            count_next         = cnt_dec;
            rsp_valid_next     = 1'b1;
            rsp_next.ok        = 1'b1;
            rsp_next.out_byte  = rd_data_reg;
            rsp_next.fill      = bfifo_pkg::FILL_W'(cnt_dec);
            rsp_next.last      = last_byte;
            rsp_next.msg_state = frame_reg;
            if (last_byte)
            begin
                state_next = ST_IDLE;
                if (flush_reg && framing)
                begin
                    frame_next         = bfifo_pkg::MSG_WAITING;
                    rsp_next.msg_state = bfifo_pkg::MSG_WAITING;
                end
            end
        end

        if (cmd_acc)
        begin
            rsp_next.ok        = 1'b0;
            rsp_next.out_byte  = '0;
            rsp_next.fill      = bfifo_pkg::FILL_W'(count_reg);
            rsp_next.msg_state = frame_reg;
            rsp_next.last      = 1'b1;
            rsp_valid_next     = 1'b1;
            unique case (cmd.func)
                bfifo_pkg::FUNC_PUSH:
                begin
                    if (count_reg != CNT_FULL)
                    begin
                        wptr_next  = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + PW'(1);
                        count_next = cnt_inc;
                        if (framing)
                        begin
                            if (cmd.push_byte == start_reg)
                            begin
                                frame_next = bfifo_pkg::MSG_READING;
                            end
                            else if (cmd.push_byte == stop_reg)
                            begin
                                frame_next = bfifo_pkg::MSG_COMPLETE;
                            end
                        end
                        rsp_next.ok        = 1'b1;
                        rsp_next.fill      = bfifo_pkg::FILL_W'(cnt_inc);
                        rsp_next.msg_state = frame_next;
                    end
                end
                bfifo_pkg::FUNC_POP, bfifo_pkg::FUNC_FLUSH:
                begin
                    if (count_reg != '0)
                    begin
                        rsp_valid_next = 1'b0;
                        state_next     = ST_DRAIN;
                        pend_next      = 1'b0;
                        flush_next     = (cmd.func == bfifo_pkg::FUNC_FLUSH);
                        left_next      = (cmd.func == bfifo_pkg::FUNC_FLUSH) ?
                                         count_reg : CW'(1);
                    end
                end
                bfifo_pkg::FUNC_CLEAR:
                begin
                    rptr_next          = '0;
                    wptr_next          = '0;
                    count_next         = '0;
                    frame_next         = bfifo_pkg::MSG_WAITING;
                    start_next         = '0;
                    stop_next          = '0;
                    rsp_next.ok        = 1'b1;
                    rsp_next.fill      = '0;
                    rsp_next.msg_state = bfifo_pkg::MSG_WAITING;
                end
                default:
                begin
                    rsp_next.ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wptr_reg] <= cmd.push_byte;
        end
        if (issue)
        begin
            rd_data_reg <= store_mem[rptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rptr_reg      <= '0;
            wptr_reg      <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            pend_reg      <= 1'b0;
            flush_reg     <= 1'b0;
            frame_reg     <= bfifo_pkg::MSG_WAITING;
            start_reg     <= '0;
            stop_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rptr_reg      <= rptr_next;
            wptr_reg      <= wptr_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            pend_reg      <= pend_next;
            flush_reg     <= flush_next;
            frame_reg     <= frame_next;
            start_reg     <= start_next;
            stop_reg      <= stop_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> test/bfifo_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for byte_fifo_with_frame_flag: tracks delimiter writes on the APB port,
// predicts the result words of every accepted command word and compares them in order.
// Depends on bfifo_pkg.

module bfifo_scoreboard (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_stall,
    input  bfifo_pkg::cmd_t cmd,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  bfifo_pkg::rsp_t rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic            pready,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output int              fail_count,
    output int              pending_cnt
);

    localparam int DEPTH = 64;

    logic [bfifo_pkg::BYTE_W-1:0] fifo_mem [DEPTH];
    logic [5:0]                   rd_ptr;
    logic [5:0]                   wr_ptr;
    logic [bfifo_pkg::FILL_W-1:0] fill_cnt;
    logic [bfifo_pkg::MSG_W-1:0]  frame_st;
    logic [bfifo_pkg::BYTE_W-1:0] start_d;
    logic [bfifo_pkg::BYTE_W-1:0] stop_d;
    bfifo_pkg::rsp_t              rsp_due [$];
    int                           err_cnt = 0;

    function automatic logic framing_on();
        return start_d != '0 && stop_d != '0;
    endfunction

    task automatic queue_word(input logic ok, input logic [bfifo_pkg::BYTE_W-1:0] data,
                              input logic last);
        bfifo_pkg::rsp_t w;
        w.ok        = ok;
        w.out_byte  = data;
        w.fill      = fill_cnt;
        w.msg_state = frame_st;
        w.last      = last;
        rsp_due.push_back(w);
    endtask

    task automatic apply_fifo_cmd(input bfifo_pkg::cmd_t c);
        logic [bfifo_pkg::BYTE_W-1:0] data;
        case (c.func)
            bfifo_pkg::FUNC_PUSH:
            begin
                if (fill_cnt == bfifo_pkg::FILL_W'(DEPTH))
                begin
                    queue_word(1'b0, '0, 1'b1);
                end
                else
                begin
                    if (framing_on())
                    begin
                        if (c.push_byte == start_d)
                            frame_st = bfifo_pkg::MSG_READING;
                        else if (c.push_byte == stop_d)
                            frame_st = bfifo_pkg::MSG_COMPLETE;
                    end
                    fifo_mem[wr_ptr] = c.push_byte;
                    wr_ptr           = wr_ptr + 6'd1;
                    fill_cnt         = fill_cnt + bfifo_pkg::FILL_W'(1);
                    queue_word(1'b1, '0, 1'b1);
                end
            end
            bfifo_pkg::FUNC_POP:
            begin
                if (fill_cnt == '0)
                begin
                    queue_word(1'b0, '0, 1'b1);
                end
                else
                begin
                    data     = fifo_mem[rd_ptr];
                    rd_ptr   = rd_ptr + 6'd1;
                    fill_cnt = fill_cnt - bfifo_pkg::FILL_W'(1);
                    queue_word(1'b1, data, 1'b1);
                end
            end
            bfifo_pkg::FUNC_FLUSH:
            begin
                if (fill_cnt == '0)
                    queue_word(1'b0, '0, 1'b1);
                while (fill_cnt != '0)
                begin
                    data     = fifo_mem[rd_ptr];
                    rd_ptr   = rd_ptr + 6'd1;
                    fill_cnt = fill_cnt - bfifo_pkg::FILL_W'(1);
                    if (fill_cnt == '0 && framing_on())
                        frame_st = bfifo_pkg::MSG_WAITING;
                    queue_word(1'b1, data, fill_cnt == '0);
                end
            end
            default:
            begin
                rd_ptr   = '0;
                wr_ptr   = '0;
                fill_cnt = '0;
                frame_st = bfifo_pkg::MSG_WAITING;
                start_d  = '0;
                stop_d   = '0;
                queue_word(1'b1, '0, 1'b1);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bfifo_pkg::rsp_t want;
        if (!rst_n)
        begin
            rd_ptr   = '0;
            wr_ptr   = '0;
            fill_cnt = '0;
            frame_st = bfifo_pkg::MSG_WAITING;
            start_d  = '0;
            stop_d   = '0;
            rsp_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {bfifo_pkg::REG_START_DELIM, 2'b00})
                    start_d = pwdata[bfifo_pkg::BYTE_W-1:0];
                else if (paddr == {bfifo_pkg::REG_STOP_DELIM, 2'b00})
                    stop_d = pwdata[bfifo_pkg::BYTE_W-1:0];
            end
            if (cmd_valid && !cmd_stall)
                apply_fifo_cmd(cmd);
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_due.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got %h", $time, rsp);
                    err_cnt++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    check_field("ok", 8'(want.ok), 8'(rsp.ok));
                    check_field("out_byte", want.out_byte, rsp.out_byte);
                    check_field("fill", 8'(want.fill), 8'(rsp.fill));
                    check_field("msg_state", 8'(want.msg_state), 8'(rsp.msg_state));
                    check_field("last", 8'(want.last), 8'(rsp.last));
                end
            end
        end
        fail_count  <= err_cnt + rsp_due.size();
        pending_cnt <= rsp_due.size();
    end

endmodule

>>> test/byte_fifo_with_frame_flag_tb.sv
`timescale 1ns / 1ps
// Top of the byte FIFO testbench: clock, reset, command and APB stimulus, verdict.
// Depends on bfifo_pkg, byte_fifo_with_frame_flag and bfifo_scoreboard.

module byte_fifo_with_frame_flag_tb;

    localparam int DEPTH = 64;

    logic            clk;
    logic            rst_n;
    logic            cmd_valid;
    logic            cmd_stall;
    bfifo_pkg::cmd_t cmd;
    logic            rsp_valid;
    logic            rsp_stall = 1'b0;
    bfifo_pkg::rsp_t rsp;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [2:0]      paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    logic        calm;
    int          fail_count;
    int          pending_cnt;
    int          n_sent;
    int          n_op [4];
    int          n_cfg;
    logic [7:0]  cur_start;
    logic [7:0]  cur_stop;

    byte_fifo_with_frame_flag #(.DEPTH(DEPTH)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bfifo_scoreboard u_sb (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending_cnt(pending_cnt)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
        rsp_stall <= (rst_n && !calm) ? ($urandom_range(99) < 26) : 1'b0;

    task automatic send_word(input logic [1:0] f, input logic [7:0] data);
        bfifo_pkg::cmd_t w;
        w.func      = f;
        w.push_byte = data;
        while (!calm && $urandom_range(99) < 26)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= w;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        n_sent++;
        n_op[f]++;
        if (f == bfifo_pkg::FUNC_CLEAR)
        begin
            cur_start = '0;
            cur_stop  = '0;
        end
    endtask

    // hold off commands until every predicted word has come back
    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_cnt != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_delims(input logic [7:0] s, input logic [7:0] e);
        logic [31:0] d;
        drain();
        d       = $urandom;
        d[7:0]  = s;
        reg_write({bfifo_pkg::REG_START_DELIM, 2'b00}, d);
        d       = $urandom;
        d[7:0]  = e;
        reg_write({bfifo_pkg::REG_STOP_DELIM, 2'b00}, d);
        cur_start = s;
        cur_stop  = e;
        n_cfg++;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return cur_start;
        if (r < 30)
            return cur_stop;
        if (r < 38)
            return 8'h00;
        if (r < 46)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic fill_to_full();
        repeat (DEPTH + 2)
            send_word(bfifo_pkg::FUNC_PUSH, pick_byte());
        send_word(bfifo_pkg::FUNC_FLUSH, 8'($urandom));
    endtask

    // mostly framed messages with random payload, some broken frames and noise
    task automatic run_mixed(input int n);
        int target;
        int k;
        logic [1:0] f;
        target = n_sent + n;
        while (n_sent < target)
        begin
            if ($urandom_range(99) < 70)
            begin
                k = $urandom_range(6);
                send_word(bfifo_pkg::FUNC_PUSH, cur_start);
                repeat (k)
                    send_word(bfifo_pkg::FUNC_PUSH, pick_byte());
                if ($urandom_range(99) < 85)
                    send_word(bfifo_pkg::FUNC_PUSH, cur_stop);
                if ($urandom_range(2) == 0)
                    send_word(bfifo_pkg::FUNC_FLUSH, 8'($urandom));
                else
                    repeat ($urandom_range(k + 3, 1))
                        send_word(bfifo_pkg::FUNC_POP, 8'($urandom));
            end
            else
            begin
                f = 2'($urandom_range(3));
                if (f == bfifo_pkg::FUNC_CLEAR && $urandom_range(2) != 0)
                    f = bfifo_pkg::FUNC_POP;
                send_word(f, 8'($urandom));
            end
        end
    endtask

    initial
    begin
        int phase;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        calm      = 1'b0;
        n_sent    = 0;
        n_op      = '{default: 0};
        n_cfg     = 0;
        cur_start = '0;
        cur_stop  = '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // framing off: refusals on empty, byte extremes, single-byte flush, clear
        send_word(bfifo_pkg::FUNC_POP, 8'h00);
        send_word(bfifo_pkg::FUNC_FLUSH, 8'h5A);
        send_word(bfifo_pkg::FUNC_PUSH, 8'h00);
        send_word(bfifo_pkg::FUNC_PUSH, 8'hFF);
        send_word(bfifo_pkg::FUNC_POP, 8'hFF);
        send_word(bfifo_pkg::FUNC_POP, 8'h00);
        send_word(bfifo_pkg::FUNC_PUSH, 8'hA5);
        send_word(bfifo_pkg::FUNC_FLUSH, 8'h00);
        send_word(bfifo_pkg::FUNC_CLEAR, 8'hC3);

        // framing on: reading, complete, flush back to waiting, clear drops delimiters
        set_delims(8'h02, 8'h03);
        send_word(bfifo_pkg::FUNC_PUSH, 8'h41);
        send_word(bfifo_pkg::FUNC_PUSH, 8'h02);
        send_word(bfifo_pkg::FUNC_PUSH, 8'h55);
        send_word(bfifo_pkg::FUNC_PUSH, 8'h03);
        send_word(bfifo_pkg::FUNC_PUSH, 8'h02);
        send_word(bfifo_pkg::FUNC_POP, 8'h00);
        send_word(bfifo_pkg::FUNC_FLUSH, 8'h00);
        send_word(bfifo_pkg::FUNC_PUSH, 8'h03);
        send_word(bfifo_pkg::FUNC_CLEAR, 8'h00);
        send_word(bfifo_pkg::FUNC_PUSH, 8'h02);
        send_word(bfifo_pkg::FUNC_POP, 8'h00);

        // equal delimiters: start takes priority
        set_delims(8'h7E, 8'h7E);
        send_word(bfifo_pkg::FUNC_PUSH, 8'h7E);
        send_word(bfifo_pkg::FUNC_FLUSH, 8'h00);

        phase = 0;
        while (n_sent < 420)
        begin
            case (phase % 6)
                0: set_delims(8'h00, 8'h00);
                1: set_delims(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)));
                2: set_delims(8'hFF, 8'h01);
                3: set_delims(8'($urandom_range(255, 1)), 8'h00);
                4: set_delims(8'h01, 8'hFF);
                default: set_delims(8'hFF, 8'hFF);
            endcase
            calm = (phase == 3 || phase == 4);
            if (phase == 2 || phase == 7)
                fill_to_full();
            else
                run_mixed(20 + $urandom_range(20));
            phase++;
        end
        calm = 1'b0;

        drain();
        repeat (20)
            @(posedge clk);
        $display("Sent %0d command words: %0d push, %0d pop, %0d flush, %0d clear",
                 n_sent, n_op[bfifo_pkg::FUNC_PUSH], n_op[bfifo_pkg::FUNC_POP],
                 n_op[bfifo_pkg::FUNC_FLUSH], n_op[bfifo_pkg::FUNC_CLEAR]);
        $display("Delimiter settings used: %0d, including full-FIFO overflow and 64-byte flush",
                 n_cfg);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
